FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file.
// Both expect signals named clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

FILE: hw/rtl/twls_pkg.sv
// ----------------------------------------------------------------------------
// twls_pkg
// Shared types and constants of the time window latency statistics block.
// ----------------------------------------------------------------------------
package twls_pkg;

    localparam int TIME_W    = 32;
    localparam int DUR_W     = 20;
    localparam int CNT_OUT_W = 9;
    localparam int DIV_CNT_W = 5;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000000;
    localparam logic DUR_MAX_BIT = 1'b1;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] time_now;
        logic [DUR_W-1:0]  duration;
    } twls_req_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] sample_count;
        logic [DUR_W-1:0]     average_duration;
        logic [DUR_W-1:0]     least_duration;
        logic [DUR_W-1:0]     greatest_duration;
    } twls_rsp_t;

    typedef struct packed {
        logic record;
        logic start_query;
        logic walk;
        logic div_step;
        logic load_out;
    } twls_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_fin;
    } twls_stat_t;

endpackage

FILE: hw/rtl/twls_ctrl.sv
// ----------------------------------------------------------------------------
// twls_ctrl
// Sequencer: accepts requests, runs the ring walk and the divide, owns the
// response valid flag.
// ----------------------------------------------------------------------------
module twls_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_type,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  twls_pkg::twls_stat_t  stat,
    output twls_pkg::twls_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       slot_free;

    assign slot_free = !valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && rsp_stall;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == twls_pkg::REQ_QUERY)
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = S_WALK;
                    end
                    else
                    begin
                        cmd.record = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_fin)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (slot_free)
                begin
                    // previous response leaves this cycle or is already gone
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: hw/rtl/twls_dpath.sv
// ----------------------------------------------------------------------------
// twls_dpath
// Sample ring, window register, walk accumulators and a radix-2 divider.
// ----------------------------------------------------------------------------
module twls_dpath
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  twls_pkg::twls_req_t                req,
    input  logic                               cfg_we,
    input  logic [twls_pkg::TIME_W-1:0]        cfg_data,
    input  twls_pkg::twls_cmd_t                cmd,
    output twls_pkg::twls_stat_t               stat,
    output twls_pkg::twls_rsp_t                rsp
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int DUR_W = twls_pkg::DUR_W;
    localparam int SUM_W = DUR_W + CNT_W;
    localparam int DCW   = twls_pkg::DIV_CNT_W;
    localparam int OW    = twls_pkg::CNT_OUT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
    localparam logic [DCW-1:0]   DIV_LAST = DCW'(DUR_W);

    logic [twls_pkg::TIME_W-1:0] stamp_mem [RING_DEPTH];
    logic [DUR_W-1:0]            dur_mem   [RING_DEPTH];

    logic [twls_pkg::TIME_W-1:0] window_reg;
    logic [IDX_W-1:0]            head_reg;
    logic [CNT_W-1:0]            fill_reg;

    logic [twls_pkg::TIME_W-1:0] now_reg;
    logic [CNT_W-1:0]            limit_reg;
    logic [CNT_W-1:0]            fetch_reg;
    logic [IDX_W-1:0]            rd_ptr_reg;
    logic                        pend_reg;
    logic                        pend_next;
    logic [twls_pkg::TIME_W-1:0] rd_stamp_reg;
    logic [DUR_W-1:0]            rd_dur_reg;

    logic [CNT_W-1:0]            count_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [DUR_W-1:0]            lo_reg;
    logic [DUR_W-1:0]            hi_reg;

    logic [CNT_W-1:0]            rem_reg;
    logic [DUR_W-1:0]            quo_reg;
    logic [DCW-1:0]              div_cnt_reg;

    twls_pkg::twls_rsp_t         rsp_reg;

    logic [twls_pkg::TIME_W-1:0] age;
    logic                        pass;
    logic                        hit_fail;
    logic                        issue;
    logic [CNT_W:0]              shifted;
    logic                        fits;
    logic [CNT_W+OW-1:0]         cnt_ext;

    assign age      = now_reg - rd_stamp_reg;
    assign pass     = (age <= window_reg);
    assign hit_fail = pend_reg && !pass;
    assign issue    = cmd.walk && !hit_fail && (fetch_reg < limit_reg);
    assign pend_next = issue;

    assign stat.walk_done = hit_fail || (!pend_reg && (fetch_reg == limit_reg));
    assign stat.div_fin   = (div_cnt_reg == DIV_LAST);

    assign shifted = {rem_reg, quo_reg[DUR_W-1]};
    assign fits    = (shifted >= {1'b0, count_reg});
    assign cnt_ext = {{OW{1'b0}}, count_reg};

    assign rsp = rsp_reg;

    // ring storage, single write port and single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            stamp_mem[head_reg] <= req.time_now;
            dur_mem[head_reg]   <= req.duration;
        end
        if (issue)
        begin
            rd_stamp_reg <= stamp_mem[rd_ptr_reg];
            rd_dur_reg   <= dur_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= twls_pkg::WINDOW_RESET;
            head_reg   <= '0;
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_we)
            begin
                window_reg <= cfg_data;
            end
            if (cmd.record)
            begin
                head_reg <= (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
                if (fill_reg != CNT_FULL)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            now_reg    <= req.time_now;
            limit_reg  <= fill_reg;
            fetch_reg  <= '0;
            rd_ptr_reg <= (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
            count_reg  <= '0;
            sum_reg    <= '0;
            lo_reg     <= {DUR_W{twls_pkg::DUR_MAX_BIT}};
            hi_reg     <= '0;
        end
        else if (cmd.walk)
        begin
            if (issue)
            begin
                fetch_reg  <= fetch_reg + 1'b1;
                rd_ptr_reg <= (rd_ptr_reg == '0) ? IDX_LAST : rd_ptr_reg - 1'b1;
            end
            if (pend_reg && pass)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(rd_dur_reg);
                if (rd_dur_reg < lo_reg)
                begin
                    lo_reg <= rd_dur_reg;
                end
                if (rd_dur_reg > hi_reg)
                begin
                    hi_reg <= rd_dur_reg;
                end
            end
            // sum is final once the walk ends; upper bits are below the count
            if (stat.walk_done)
            begin
                rem_reg     <= sum_reg[SUM_W-1:DUR_W];
                quo_reg     <= sum_reg[DUR_W-1:0];
                div_cnt_reg <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (fits)
            begin
                rem_reg <= CNT_W'(shifted - {1'b0, count_reg});
                quo_reg <= {quo_reg[DUR_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[CNT_W-1:0];
                quo_reg <= {quo_reg[DUR_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (count_reg == '0)
            begin
                rsp_reg <= '0;
            end
            else
            begin
                rsp_reg.sample_count      <= cnt_ext[OW-1:0];
                rsp_reg.average_duration  <= quo_reg;
                rsp_reg.least_duration    <= lo_reg;
                rsp_reg.greatest_duration <= hi_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/time_window_latency_stats.sv
// ----------------------------------------------------------------------------
// time_window_latency_stats
// Sliding time-window count, average, minimum and maximum of durations.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_data): a record request stores
//   time_now and duration at the ring head; a query request carries the
//   current time and yields one response on the rsp channel.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes window_length in
//   microseconds; cfg_ready is always high, write only while idle.
// Timing:
//   A record is taken while idle; the next request may follow immediately.
//   A query visits N samples, each read through the single ring read
//   port, then drains the last read, closes the walk, runs 20 divider
//   steps (one quotient bit per cycle) and loads the response.
//   req_stall is high for the whole query.
// Reset: ring head and fill count clear, window_length returns to 1000000;
//   ring contents are not cleared and need no sweep.
// Stall: a response waits in the output register while rsp_stall is high;
//   records are still taken, and a later query waits before loading.
// ----------------------------------------------------------------------------
module time_window_latency_stats
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  twls_pkg::twls_req_t         req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output twls_pkg::twls_rsp_t         rsp_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [twls_pkg::TIME_W-1:0] cfg_data
);

    twls_pkg::twls_cmd_t  cmd;
    twls_pkg::twls_stat_t stat;

    assign cfg_ready = 1'b1;

    twls_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    twls_dpath
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp_data)
    );

endmodule

FILE: hw/rtl/twls_checker.sv
// ----------------------------------------------------------------------------
// twls_checker
// Port-level checks of the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twls_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_stall,
    input twls_pkg::twls_req_t         req_data,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input twls_pkg::twls_rsp_t         rsp_data
);

    logic avg_in_range;

    assign avg_in_range = (rsp_data.least_duration <= rsp_data.average_duration) &&
                          (rsp_data.average_duration <= rsp_data.greatest_duration);

    `ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
    `ASSERT_NXT(a_query_busy, req_valid && !req_stall && req_data.req_type, req_stall)
    `ASSERT_IMP(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall))
    `ASSERT_IMP(a_avg_bounds, rsp_valid && (rsp_data.sample_count != '0), avg_in_range)

endmodule

bind time_window_latency_stats twls_checker u_twls_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding time-window latency statistics block.
// Record and query requests go in; a scoreboard tracks its own copy of the
// ring and the window register. Each query response is checked field by
// field against the scoreboard. The bench writes several window settings,
// including 1 and the largest value. Requests come in random bursts and the
// receiver stalls at random or in a fixed pattern, with one long receiver
// hold-off to back up the request channel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RING_DEPTH    = 256;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 3000;
    localparam int PHASE_ITEMS   = 300;

    class window_stats_sb;
        logic [twls_pkg::TIME_W-1:0] stamp_mem [RING_DEPTH];
        logic [twls_pkg::DUR_W-1:0]  dur_mem [RING_DEPTH];
        int unsigned                 head;
        int unsigned                 fill;
        logic [twls_pkg::TIME_W-1:0] window;
        twls_pkg::twls_rsp_t         expected_stats [$];
        int unsigned                 errors;
        int unsigned                 records;
        int unsigned                 queries;
        int unsigned                 checked;
        int unsigned                 empty_hits;
        int unsigned                 max_fill;

        function new();
            head       = 0;
            fill       = 0;
            window     = twls_pkg::WINDOW_RESET;
            errors     = 0;
            records    = 0;
            queries    = 0;
            checked    = 0;
            empty_hits = 0;
            max_fill   = 0;
        endfunction

        function void set_window(logic [twls_pkg::TIME_W-1:0] w);
            window = w;
        endfunction

        // walk back from the newest sample until one falls outside the window
        function twls_pkg::twls_rsp_t window_stats(logic [twls_pkg::TIME_W-1:0] now);
            twls_pkg::twls_rsp_t         r;
            logic [twls_pkg::TIME_W-1:0] age;
            logic [twls_pkg::DUR_W-1:0]  d;
            logic [twls_pkg::DUR_W-1:0]  lo;
            logic [twls_pkg::DUR_W-1:0]  hi;
            longint unsigned             sum;
            int unsigned                 n;
            int unsigned                 idx;
            lo  = '1;
            hi  = '0;
            sum = 0;
            n   = 0;
            for (int i = 0; i < fill; i++)
            begin
                idx = (head + RING_DEPTH - 1 - i) % RING_DEPTH;
                age = now - stamp_mem[idx];
                if (age > window)
                    break;
                d = dur_mem[idx];
                n++;
                sum += d;
                if (d < lo)
                    lo = d;
                if (d > hi)
                    hi = d;
            end
            r = '0;
            if (n != 0)
            begin
                r.sample_count      = twls_pkg::CNT_OUT_W'(n);
                r.average_duration  = twls_pkg::DUR_W'(sum / n);
                r.least_duration    = lo;
                r.greatest_duration = hi;
            end
            return r;
        endfunction

        function void note_request(twls_pkg::twls_req_t rq);
            twls_pkg::twls_rsp_t s;
            if (rq.req_type == twls_pkg::REQ_RECORD)
            begin
                stamp_mem[head] = rq.time_now;
                dur_mem[head]   = rq.duration;
                head = (head + 1) % RING_DEPTH;
                if (fill < RING_DEPTH)
                    fill++;
                if (fill > max_fill)
                    max_fill = fill;
                records++;
            end
            else
            begin
                s = window_stats(rq.time_now);
                if (s.sample_count == 0)
                    empty_hits++;
                expected_stats.push_back(s);
                queries++;
            end
        endfunction

        task report(string what, int unsigned want_v, int unsigned got_v);
            errors++;
            if (errors <= 50)
                $display("mismatch %s: expected %0d got %0d (response %0d)",
                         what, want_v, got_v, checked);
        endtask

        task check_response(twls_pkg::twls_rsp_t got);
            twls_pkg::twls_rsp_t want;
            if (expected_stats.size() == 0)
            begin
                report("unexpected response, sample_count", 0, got.sample_count);
                return;
            end
            want = expected_stats.pop_front();
            checked++;
            if (got.sample_count != want.sample_count)
                report("sample_count", want.sample_count, got.sample_count);
            if (got.average_duration != want.average_duration)
                report("average_duration", want.average_duration, got.average_duration);
            if (got.least_duration != want.least_duration)
                report("least_duration", want.least_duration, got.least_duration);
            if (got.greatest_duration != want.greatest_duration)
                report("greatest_duration", want.greatest_duration, got.greatest_duration);
        endtask
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    twls_pkg::twls_req_t         req_data  = '0;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    twls_pkg::twls_rsp_t         rsp_data;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [twls_pkg::TIME_W-1:0] cfg_data  = '0;

    window_stats_sb              sb = new();

    // request generator state
    logic [twls_pkg::TIME_W-1:0] cur_time   = '0;
    logic [twls_pkg::TIME_W-1:0] gen_window = twls_pkg::WINDOW_RESET;
    logic [twls_pkg::TIME_W-1:0] sent_stamps [$];
    int unsigned                 windows_used = 0;

    // receiver control
    int unsigned                 rx_mode  = 0;
    bit                          hold_rsp = 1'b0;

    time_window_latency_stats #(.RING_DEPTH(RING_DEPTH)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("[time_window_latency_stats] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_data);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp_data);
            if (cfg_valid && cfg_ready)
                sb.set_window(cfg_data);
        end
    end

    // response side: stall pattern per phase, plus one long hold-off on demand
    initial
    begin
        int unsigned tick;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
                rsp_stall <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 99) < 30);
                    2:       rsp_stall <= ((tick % 7) < 3);
                    default: rsp_stall <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    function automatic twls_pkg::twls_req_t make_req(logic kind,
                                                     logic [twls_pkg::TIME_W-1:0] t,
                                                     logic [twls_pkg::DUR_W-1:0] d);
        twls_pkg::twls_req_t r;
        r.req_type = kind;
        r.time_now = t;
        r.duration = d;
        return r;
    endfunction

    // well-formed time stream: small steps relative to the window, with
    // occasional repeats and jumps; queries often land on a window edge
    function automatic twls_pkg::twls_req_t random_req();
        twls_pkg::twls_req_t         r;
        logic [twls_pkg::TIME_W-1:0] span;
        span       = (gen_window >> 4) + 1;
        r.req_type = twls_pkg::REQ_RECORD;
        r.time_now = $urandom;
        r.duration = twls_pkg::DUR_W'($urandom);
        if ($urandom_range(0, 99) < 70)
        begin
            case ($urandom_range(0, 9))
                0, 1:    ;
                8:       cur_time += $urandom_range(0, gen_window);
                9:       cur_time += $urandom;
                default: cur_time += $urandom_range(0, span);
            endcase
            r.time_now = cur_time;
            case ($urandom_range(0, 9))
                0:       r.duration = '0;
                1:       r.duration = '1;
                2:       r.duration = twls_pkg::DUR_W'($urandom_range(0, 15));
                default: ;
            endcase
            sent_stamps.push_back(cur_time);
            if (sent_stamps.size() > RING_DEPTH)
                void'(sent_stamps.pop_front());
        end
        else
        begin
            r.req_type = twls_pkg::REQ_QUERY;
            case ($urandom_range(0, 7))
                0: r.time_now = cur_time;
                1: r.time_now = cur_time - 1;
                2, 3:
                begin
                    if (sent_stamps.size() > 0)
                        r.time_now = sent_stamps[$urandom_range(0, sent_stamps.size() - 1)]
                                     + gen_window + $urandom_range(0, 1);
                end
                4:       ;
                default: r.time_now = cur_time + $urandom_range(0, span * 4);
            endcase
        end
        return r;
    endfunction

    task automatic send_req(twls_pkg::twls_req_t r);
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic idle_sender(int unsigned n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // sender pauses until every query has been answered
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [twls_pkg::TIME_W-1:0] w);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        gen_window = w;
        windows_used++;
    endtask

    task automatic run_phase(logic [twls_pkg::TIME_W-1:0] w, int unsigned gap_max,
                             bit pressure);
        int unsigned sent;
        int unsigned burst;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        write_window(w);
        if (pressure)
            hold_rsp = 1'b1;
        while (sent < PHASE_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < PHASE_ITEMS)
            begin
                send_req(random_req());
                sent++;
                burst--;
            end
            if (!paused && sent >= PHASE_ITEMS / 2)
            begin
                wait_quiet();
                paused = 1'b1;
            end
            else
                idle_sender($urandom_range(0, gap_max));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty ring, window edges, stamps ahead of now, wrap
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd500, '0));
        send_req(make_req(twls_pkg::REQ_RECORD, 32'd100, '1));
        send_req(make_req(twls_pkg::REQ_RECORD, 32'd200, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd200, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd150, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd1000200, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd1000201, '0));
        send_req(make_req(twls_pkg::REQ_RECORD, 32'hFFFF_FFF0, 20'd5));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'h0000_0010, '0));
        write_window(32'hFFFF_FFFF);
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd0, '0));
        write_window(32'd1);
        send_req(make_req(twls_pkg::REQ_RECORD, 32'd5000, 20'd7));
        send_req(make_req(twls_pkg::REQ_RECORD, 32'd5001, 20'd9));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd5001, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd5002, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'd5003, '0));
        send_req(make_req(twls_pkg::REQ_QUERY, 32'hFFFF_FFFF, '1));
        cur_time = 32'd5001;

        rx_mode = 1;
        run_phase(twls_pkg::WINDOW_RESET, 12, 1'b0);
        rx_mode = 2;
        run_phase(32'd1, 4, 1'b0);
        rx_mode = 0;
        run_phase(32'hFFFF_FFFF, 0, 1'b1);
        rx_mode = 3;
        run_phase($urandom_range(2, 5000), 20, 1'b0);
        rx_mode = 1;
        run_phase($urandom | 32'd1, 8, 1'b0);
        rx_mode = 0;
        run_phase(32'h8000_0000, 3, 1'b0);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d records and %0d queries (%0d empty) over %0d window writes",
                 sb.records, sb.queries, sb.empty_hits, windows_used);
        $display("checked %0d responses, ring fill peaked at %0d, %0d mismatches",
                 sb.checked, sb.max_fill, sb.errors);
        if (sb.errors == 0)
            $display("[time_window_latency_stats] OK");
        else
            $display("[time_window_latency_stats] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/twls_pkg.sv
hw/rtl/twls_ctrl.sv
hw/rtl/twls_dpath.sv
hw/rtl/time_window_latency_stats.sv
hw/rtl/twls_checker.sv
dv/tb_top.sv
